// ===== rtl/core/tdfa_pkg.sv =====
`default_nettype none

package tdfa_pkg;

    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 4;

    localparam int STATE_W = 5;
    localparam int SYM_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int CAUSE_W = 2;
    localparam int MASK_W  = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_ACCEPT = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_REJECT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_SYMBOL = 2'd2;

    localparam logic [1:0] REG_ALPHA_CHARS = 2'd0;
    localparam logic [1:0] REG_ALPHA_SIZE  = 2'd1;
    localparam logic [1:0] REG_START_STATE = 2'd2;
    localparam logic [1:0] REG_ACCEPT_MASK = 2'd3;

    localparam logic [2:0]         ALPHA_SIZE_RST = 3'd1;
    localparam logic [STATE_W-1:0] START_RST      = 5'd1;

    typedef struct packed {
        logic [31:0]         alpha_chars;
        logic [2:0]          alpha_size;
        logic [STATE_W-1:0]  start_state;
        logic [MASK_W-1:0]   accept_mask;
        logic                start_wr;
    } t_cfg;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int addr_w(input int n_states, input int n_symbols);
        return idx_w(n_states) + idx_w(n_symbols);
    endfunction

    function automatic logic st_in_range(input logic [STATE_W-1:0] s, input int n_states);
        return (s != '0) && (int'(s) <= n_states);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/table_driven_dfa_recognizer_core.sv =====
`default_nettype none

// Channel   Dir  Beat contents (lowest bit first)
// s_*       in   tdata: from_state[4:0] symbol_index[6:5] to_state[11:7] char_code[19:12]
//                tuser: operation, tlast: last
// m_*       out  tdata: accepted[0] cause[2:1]
// APB       in   regs at 0x0 alphabet_chars, 0x4 alphabet_size, 0x8 start_state,
//                0xC accept_mask
//
// One item per cycle on s_* while s_tready is high; each character does at most one read of the transition RAM,
// whose registered output feeds the next character's read address directly.
// A result passes through the finish register and then the output register before it leaves on m_*.
// s_tready drops only while a finished result waits and the output register is held.
// Synchronous active-low reset; the transition RAM is not cleared.

module table_driven_dfa_recognizer_core #(
    parameter int NUM_STATES  = tdfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = tdfa_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // from_state, symbol_index, to_state, char_code
    input  wire logic        s_tuser,   // operation
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // accepted, cause
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tdfa_pkg::*;

    localparam int RW = idx_w(NUM_STATES);
    localparam int CW = idx_w(NUM_SYMBOLS);
    localparam int AW = addr_w(NUM_STATES, NUM_SYMBOLS);

    t_cfg               w_cfg;
    logic [STATE_W-1:0] w_from;
    logic [SYM_W-1:0]   w_sym;
    logic [STATE_W-1:0] w_to;
    logic [CHAR_W-1:0]  w_char;
    logic               w_found;
    logic [SYM_W-1:0]   w_idx;
    logic [STATE_W-1:0] w_mem_q;

    logic [STATE_W-1:0] r_state, n_state;
    logic               r_mem_pend, n_mem_pend;
    logic               r_failed, n_failed;
    logic               r_fin_valid, n_fin_valid;
    logic               r_fin_use_mem;
    logic [STATE_W-1:0] r_fin_state;
    logic               r_fin_fail;
    logic               r_out_valid, n_out_valid;
    logic               r_out_acc;
    logic [CAUSE_W-1:0] r_out_cause;

    logic               s_fire;
    logic               s_char;
    logic               s_load;
    logic               s_out_free;
    logic               s_fin_move;
    logic [STATE_W-1:0] s_cur;
    logic               s_use_mem;
    logic [8:0]         s_cur_row;
    logic [8:0]         s_ld_row;
    logic               s_we;
    logic [AW-1:0]      s_waddr;
    logic [AW-1:0]      s_raddr;
    logic [STATE_W-1:0] s_fin_st;
    logic               s_fin_acc;
    logic [CAUSE_W-1:0] s_fin_cause;

    assign w_from = s_tdata[4:0];
    assign w_sym  = s_tdata[6:5];
    assign w_to   = s_tdata[11:7];
    assign w_char = s_tdata[19:12];

    tdfa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tdfa_match #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_match (
        .i_char        (w_char),
        .i_alpha_chars (w_cfg.alpha_chars),
        .i_alpha_size  (w_cfg.alpha_size),
        .o_found       (w_found),
        .o_idx         (w_idx)
    );

    tdfa_table #(.NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_table (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (w_to),
        .i_re    (s_use_mem),
        .i_raddr (s_raddr),
        .o_rdata (w_mem_q)
    );

    assign s_out_free = !r_out_valid || m_tready;
    assign s_fin_move = r_fin_valid && s_out_free;
    assign s_tready   = !r_fin_valid || s_out_free;
    assign s_fire     = s_tvalid && s_tready;
    assign s_char     = s_fire && (s_tuser == OP_CHAR);
    assign s_load     = s_fire && (s_tuser == OP_LOAD);

    // forward the RAM output as the current state while a lookup is in flight
    assign s_cur     = r_mem_pend ? w_mem_q : r_state;
    assign s_use_mem = s_char && !r_failed && w_found && st_in_range(s_cur, NUM_STATES);
    assign s_cur_row = 9'(s_cur) - 9'd1;
    assign s_raddr   = {s_cur_row[RW-1:0], CW'(w_idx)};

    assign s_ld_row = 9'(w_from) - 9'd1;
    assign s_we     = s_load && st_in_range(w_from, NUM_STATES) && (int'(w_sym) < NUM_SYMBOLS);
    assign s_waddr  = {s_ld_row[RW-1:0], CW'(w_sym)};

    always_comb begin
        n_state     = r_state;
        n_mem_pend  = r_mem_pend;
        n_failed    = r_failed;
        n_fin_valid = r_fin_valid && !s_fin_move;
        if (w_cfg.start_wr) begin
            n_state    = pwdata[STATE_W-1:0];
            n_mem_pend = 1'b0;
        end else if (s_char) begin
            if (s_tlast) begin
                n_state     = w_cfg.start_state;
                n_mem_pend  = 1'b0;
                n_failed    = 1'b0;
                n_fin_valid = 1'b1;
            end else begin
                n_state    = s_cur;
                n_mem_pend = s_use_mem;
                n_failed   = r_failed || !w_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= START_RST;
            r_mem_pend  <= 1'b0;
            r_failed    <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mem_pend  <= n_mem_pend;
            r_failed    <= n_failed;
            r_fin_valid <= n_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_char && s_tlast) begin
            r_fin_use_mem <= s_use_mem;
            r_fin_state   <= s_cur;
            r_fin_fail    <= r_failed || !w_found;
        end
    end

    assign s_fin_st  = r_fin_use_mem ? w_mem_q : r_fin_state;
    assign s_fin_acc = st_in_range(s_fin_st, NUM_STATES) && (s_fin_st <= 5'd16) &&
                       w_cfg.accept_mask[4'(s_fin_st - 5'd1)];

    always_comb begin
        if (r_fin_fail) begin
            s_fin_cause = CAUSE_SYMBOL;
        end else if (s_fin_acc) begin
            s_fin_cause = CAUSE_ACCEPT;
        end else begin
            s_fin_cause = CAUSE_REJECT;
        end
    end

    assign n_out_valid = s_fin_move || (r_out_valid && !m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fin_move) begin
            r_out_acc   <= !r_fin_fail && s_fin_acc;
            r_out_cause <= s_fin_cause;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out_cause, r_out_acc};

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_fin_valid && r_out_valid && !m_tready))
        else $error("input stalled without a held result");

    a_fin_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fin_move |=> m_tvalid)
        else $error("finished result not registered");

    a_start_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.start_wr |=> (!r_mem_pend && r_state == w_cfg.start_state))
        else $error("start state write not applied");

    a_accept_matches_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == CAUSE_ACCEPT)))
        else $error("accepted flag disagrees with cause");

    a_last_resets_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_char && s_tlast && !w_cfg.start_wr) |=> (!r_failed && !r_mem_pend && r_fin_valid))
        else $error("walk not restarted after last beat");

endmodule

`default_nettype wire

// ===== rtl/core/tdfa_cfg.sv =====
`default_nettype none

module tdfa_cfg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output tdfa_pkg::t_cfg           o_cfg
);
    import tdfa_pkg::*;

    logic [31:0]        r_alpha_chars;
    logic [2:0]         r_alpha_size;
    logic [STATE_W-1:0] r_start_state;
    logic [MASK_W-1:0]  r_accept_mask;
    logic               s_wr;
    logic [1:0]         s_reg;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && pready;
    assign s_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_chars <= '0;
            r_alpha_size  <= ALPHA_SIZE_RST;
            r_start_state <= START_RST;
            r_accept_mask <= '0;
        end else if (s_wr) begin
            case (s_reg)
                REG_ALPHA_CHARS: r_alpha_chars <= pwdata;
                REG_ALPHA_SIZE:  r_alpha_size  <= pwdata[2:0];
                REG_START_STATE: r_start_state <= pwdata[STATE_W-1:0];
                REG_ACCEPT_MASK: r_accept_mask <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_reg)
            REG_ALPHA_CHARS: prdata = r_alpha_chars;
            REG_ALPHA_SIZE:  prdata = {29'd0, r_alpha_size};
            REG_START_STATE: prdata = {27'd0, r_start_state};
            REG_ACCEPT_MASK: prdata = {16'd0, r_accept_mask};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.alpha_chars = r_alpha_chars;
        o_cfg.alpha_size  = r_alpha_size;
        o_cfg.start_state = r_start_state;
        o_cfg.accept_mask = r_accept_mask;
        o_cfg.start_wr    = s_wr && (s_reg == REG_START_STATE);
    end

endmodule

`default_nettype wire

// ===== rtl/core/tdfa_match.sv =====
`default_nettype none

module tdfa_match #(
    parameter int NUM_SYMBOLS = tdfa_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic [tdfa_pkg::CHAR_W-1:0] i_char,
    input  wire logic [31:0]                 i_alpha_chars,
    input  wire logic [2:0]                  i_alpha_size,
    output logic                             o_found,
    output logic [tdfa_pkg::SYM_W-1:0]       o_idx
);
    import tdfa_pkg::*;

    // lowest matching index wins: scan from the top down
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int j = 3; j >= 0; j--) begin
            if ((j < NUM_SYMBOLS) && (3'(j) < i_alpha_size) &&
                (i_alpha_chars[8*j +: 8] == i_char)) begin
                o_found = 1'b1;
                o_idx   = SYM_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tdfa_table.sv =====
`default_nettype none

module tdfa_table #(
    parameter int NUM_STATES  = tdfa_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = tdfa_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic                                                i_clk,
    input  wire logic                                                i_we,
    input  wire logic [tdfa_pkg::addr_w(NUM_STATES, NUM_SYMBOLS)-1:0] i_waddr,
    input  wire logic [tdfa_pkg::STATE_W-1:0]                        i_wdata,
    input  wire logic                                                i_re,
    input  wire logic [tdfa_pkg::addr_w(NUM_STATES, NUM_SYMBOLS)-1:0] i_raddr,
    output logic [tdfa_pkg::STATE_W-1:0]                             o_rdata
);
    import tdfa_pkg::*;

    localparam int AW    = addr_w(NUM_STATES, NUM_SYMBOLS);
    localparam int DEPTH = 1 << AW;

    logic [STATE_W-1:0] r_mem [DEPTH];
    logic [STATE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
